>>> sv/tlpc_pkg.sv
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants of the traffic light phase controller
// Word formats, key codes, phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  // Request word: one base tick or one key press.
  typedef struct packed {
    logic       req_type;
    logic [2:0] key_code;
  } tlpc_req_t;

  // Response word: lamps, countdowns and phase after the request.
  typedef struct packed {
    logic       ns_red;
    logic       ns_yellow;
    logic       ns_green;
    logic       ew_red;
    logic       ew_yellow;
    logic       ew_green;
    logic [6:0] ns_count;
    logic [6:0] ew_count;
    logic [2:0] phase;
    logic       running;
  } tlpc_rsp_t;

  // Request types
  localparam logic ReqTick = 1'b0;
  localparam logic ReqKey  = 1'b1;

  // Key codes
  localparam logic [2:0] KeyRun  = 3'd1;
  localparam logic [2:0] KeyDec  = 3'd2;
  localparam logic [2:0] KeyInc  = 3'd3;
  localparam logic [2:0] KeyStep = 3'd4;

  // Phase codes
  localparam logic [2:0] PhNsGreen  = 3'd0;
  localparam logic [2:0] PhNsYellow = 3'd1;
  localparam logic [2:0] PhEwGreen  = 3'd2;
  localparam logic [2:0] PhEwYellow = 3'd3;
  localparam logic [2:0] PhAllYel   = 3'd4;
  localparam logic [2:0] PhEwGo     = 3'd5;
  localparam logic [2:0] PhNsGo     = 3'd6;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegYellow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFlash    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPerLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPerHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitPer  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTicksSec = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTicksFl  = 3'd6;

  // Register reset values
  localparam logic [3:0] YellowRst   = 4'd2;
  localparam logic [3:0] FlashRst    = 4'd3;
  localparam logic [6:0] PerLowRst   = 7'd20;
  localparam logic [6:0] PerHighRst  = 7'd60;
  localparam logic [6:0] InitPerRst  = 7'd10;
  localparam logic [7:0] TicksSecRst = 8'd20;
  localparam logic [7:0] TicksFlRst  = 8'd10;

  // Largest displayable count
  localparam logic [6:0] MaxCount = 7'd99;

endpackage

>>> sv/tlpc_stream_if.sv
// ----------------------------------------------------------------------------
// tlpc_stream_if: valid/ready channel
// Carries one word of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface tlpc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/traffic_light_phase_controller_core.sv
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_core: two-road traffic light controller
// Tick and key words in, one lamp/countdown word out per request.
// ----------------------------------------------------------------------------
// Every request word yields exactly one response word, registered in the cycle
// after the request is taken. The full state update and the lamp and count
// decode sit between the request handshake and a single response register, so
// a new request is taken in every cycle as long as the response side keeps
// up; while a response waits, ready stays high if the sink takes it in the
// same cycle. Configuration writes are registered and are meant for when
// the block is idle; writing the initial period also reloads the countdown.
module traffic_light_phase_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tlpc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  tlpc_stream_if.sink                    req,
  tlpc_stream_if.source                  rsp
);
  import tlpc_pkg::*;

  // Configuration registers
  logic [3:0] yellow_q,  yellow_d;
  logic [3:0] flash_q,   flash_d;
  logic [6:0] per_low_q, per_low_d;
  logic [6:0] per_hi_q,  per_hi_d;
  logic [6:0] init_q,    init_d;
  logic [7:0] tps_q,     tps_d;
  logic [7:0] tpf_q,     tpf_d;

  // Controller state
  logic [2:0] phase_q,     phase_d;
  logic [6:0] secs_q,      secs_d;
  logic [6:0] reload_q,    reload_d;
  logic       run_q,       run_d;
  logic [1:0] presses_q,   presses_d;
  logic [2:0] saved_q,     saved_d;
  logic [7:0] sec_pre_q,   sec_pre_d;
  logic [7:0] flash_pre_q, flash_pre_d;
  logic       flash_off_q, flash_off_d;

  // Response register
  logic      rsp_valid_q, rsp_valid_d;
  tlpc_rsp_t rsp_data_q,  rsp_d;

  logic      req_accept;
  tlpc_req_t req_word;

  assign req_word   = req.data;
  assign req.ready  = ~rsp_valid_q | rsp.ready;
  assign req_accept = req.valid & req.ready;

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_data_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin : next_state
    logic [7:0] fp_inc;
    logic [7:0] sp_inc;
    logic [6:0] s_tmp;
    logic [2:0] ph_tmp;
    logic [2:0] press_inc;
    logic [7:0] raise_sum;

    fp_inc    = flash_pre_q + 8'd1;
    sp_inc    = sec_pre_q + 8'd1;
    s_tmp     = secs_q;
    ph_tmp    = phase_q;
    press_inc = {1'b0, presses_q} + 3'd1;
    raise_sum = {1'b0, secs_q} + {4'b0, yellow_q};

    yellow_d    = yellow_q;
    flash_d     = flash_q;
    per_low_d   = per_low_q;
    per_hi_d    = per_hi_q;
    init_d      = init_q;
    tps_d       = tps_q;
    tpf_d       = tpf_q;
    phase_d     = phase_q;
    secs_d      = secs_q;
    reload_d    = reload_q;
    run_d       = run_q;
    presses_d   = presses_q;
    saved_d     = saved_q;
    sec_pre_d   = sec_pre_q;
    flash_pre_d = flash_pre_q;
    flash_off_d = flash_off_q;

    if (req_accept) begin
      if (req_word.req_type == ReqTick) begin
        // Flash toggle runs on every tick
        if (fp_inc >= tpf_q) begin
          flash_pre_d = '0;
          flash_off_d = ~flash_off_q;
        end else begin
          flash_pre_d = fp_inc;
        end
        // Second count only while running in an automatic phase
        if (run_q && !phase_q[2]) begin
          if (sp_inc >= tps_q) begin
            sec_pre_d = '0;
            if (secs_q <= 7'd1) begin
              s_tmp  = reload_q;
              ph_tmp = {1'b0, phase_q[1:0] + 2'd1};
            end else begin
              s_tmp  = secs_q - 7'd1;
              ph_tmp = phase_q;
            end
            // Advance the phase on landing at the yellow point
            if (s_tmp == {3'b0, yellow_q}) begin
              ph_tmp = {1'b0, ph_tmp[1:0] + 2'd1};
            end
            secs_d  = s_tmp;
            phase_d = ph_tmp;
          end else begin
            sec_pre_d = sp_inc;
          end
        end
      end else begin
        unique case (req_word.key_code)
          KeyStep: begin
            if (press_inc == 3'd1) begin
              saved_d = phase_q;
            end
            run_d = 1'b0;
            if (press_inc[2]) begin
              // Fourth press: restore the saved automatic phase
              phase_d   = saved_d[2] ? PhNsGreen : saved_d;
              run_d     = 1'b1;
              presses_d = '0;
            end else begin
              phase_d   = PhEwYellow + press_inc;
              presses_d = press_inc[1:0];
            end
          end
          KeyInc: begin
            if (!run_q && !phase_q[2] && secs_q < per_hi_q) begin
              s_tmp    = (raise_sum > {1'b0, MaxCount}) ? MaxCount : raise_sum[6:0];
              secs_d   = s_tmp;
              reload_d = s_tmp;
            end
          end
          KeyDec: begin
            if (!run_q && !phase_q[2] && secs_q > per_low_q) begin
              s_tmp    = ({1'b0, secs_q} > ({4'b0, yellow_q} + 8'd1)) ?
                         (secs_q - {3'b0, yellow_q}) : 7'd1;
              secs_d   = s_tmp;
              reload_d = s_tmp;
            end
          end
          KeyRun: begin
            if (!phase_q[2]) begin
              run_d = ~run_q;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegYellow:   yellow_d  = cfg_wdata_i[3:0];
        RegFlash:    flash_d   = cfg_wdata_i[3:0];
        RegPerLow:   per_low_d = cfg_wdata_i[6:0];
        RegPerHigh:  per_hi_d  = cfg_wdata_i[6:0];
        RegInitPer: begin
          init_d   = cfg_wdata_i[6:0];
          secs_d   = cfg_wdata_i[6:0];
          reload_d = cfg_wdata_i[6:0];
        end
        RegTicksSec: tps_d     = cfg_wdata_i;
        RegTicksFl:  tpf_d     = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Response decode from the updated state
  // --------------------------------------------------------------------------
  always_comb begin : rsp_decode
    logic [6:0] other;
    logic       green;
    logic [6:0] nc;
    logic [6:0] ec;

    other = (secs_d > {3'b0, yellow_q}) ? (secs_d - {3'b0, yellow_q}) : secs_d;
    green = ({1'b0, secs_d} > ({4'b0, yellow_q} + {4'b0, flash_q})) ? 1'b1 :
            ~flash_off_d;
    nc    = '0;
    ec    = '0;
    rsp_d = '0;

    unique case (phase_d)
      PhNsGreen: begin
        rsp_d.ew_red   = 1'b1;
        rsp_d.ns_green = green;
        nc = secs_d;
        ec = other;
      end
      PhNsYellow: begin
        rsp_d.ew_red    = 1'b1;
        rsp_d.ns_yellow = 1'b1;
        nc = secs_d;
        ec = other;
      end
      PhEwGreen: begin
        rsp_d.ns_red   = 1'b1;
        rsp_d.ew_green = green;
        ec = secs_d;
        nc = other;
      end
      PhEwYellow: begin
        rsp_d.ns_red    = 1'b1;
        rsp_d.ew_yellow = 1'b1;
        ec = secs_d;
        nc = other;
      end
      PhAllYel: begin
        rsp_d.ns_yellow = 1'b1;
        rsp_d.ew_yellow = 1'b1;
      end
      PhEwGo: begin
        rsp_d.ew_green = 1'b1;
        rsp_d.ns_red   = 1'b1;
      end
      default: begin
        rsp_d.ns_green = 1'b1;
        rsp_d.ew_red   = 1'b1;
      end
    endcase

    rsp_d.ns_count = (nc > MaxCount) ? MaxCount : nc;
    rsp_d.ew_count = (ec > MaxCount) ? MaxCount : ec;
    rsp_d.phase    = phase_d;
    rsp_d.running  = run_d;
  end

  // Hold the response until the sink takes it
  assign rsp_valid_d = req_accept | (rsp_valid_q & ~rsp.ready);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yellow_q    <= YellowRst;
      flash_q     <= FlashRst;
      per_low_q   <= PerLowRst;
      per_hi_q    <= PerHighRst;
      init_q      <= InitPerRst;
      tps_q       <= TicksSecRst;
      tpf_q       <= TicksFlRst;
      phase_q     <= PhNsGreen;
      secs_q      <= InitPerRst;
      reload_q    <= InitPerRst;
      run_q       <= 1'b1;
      presses_q   <= '0;
      saved_q     <= PhNsGreen;
      sec_pre_q   <= '0;
      flash_pre_q <= '0;
      flash_off_q <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      yellow_q    <= yellow_d;
      flash_q     <= flash_d;
      per_low_q   <= per_low_d;
      per_hi_q    <= per_hi_d;
      init_q      <= init_d;
      tps_q       <= tps_d;
      tpf_q       <= tpf_d;
      phase_q     <= phase_d;
      secs_q      <= secs_d;
      reload_q    <= reload_d;
      run_q       <= run_d;
      presses_q   <= presses_d;
      saved_q     <= saved_d;
      sec_pre_q   <= sec_pre_d;
      flash_pre_q <= flash_pre_d;
      flash_off_q <= flash_off_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rsp_data_q <= rsp_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A manual phase always stops the countdown
  a_manual_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q[2] |-> !run_q)
    else $error("countdown running in a manual phase");

  // Press count is nonzero exactly while in a manual phase
  a_press_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (presses_q != 2'd0) == phase_q[2])
    else $error("manual press count out of step with phase");

  // Every taken request shows up as a response word
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> rsp_valid_q)
    else $error("request taken without a response");

  // Flash prescaler moves only on a taken tick
  a_flash_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_accept && req_word.req_type == ReqTick) |=> $stable(flash_pre_q))
    else $error("flash prescaler moved without a tick");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the traffic light phase controller core
// Sends tick and key words under random stalls on both channels. A model of
// the lamps, countdowns and phases predicts every response word, and each
// word is checked field by field. Timing registers change between bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import tlpc_pkg::*;

  localparam int StallLimit = 1000;
  localparam int PrintLimit = 50;
  localparam int BurstItems = 120;
  localparam int NumBursts  = 9;

  // Key codes with no function; the block must still answer them
  localparam logic [2:0] KeyZero  = 3'd0;
  localparam logic [2:0] KeyFive  = 3'd5;
  localparam logic [2:0] KeySix   = 3'd6;
  localparam logic [2:0] KeySeven = 3'd7;

  // Index past the last register; writes to it are dropped
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  tlpc_stream_if #(.payload_t(tlpc_req_t)) req_if ();
  tlpc_stream_if #(.payload_t(tlpc_rsp_t)) rsp_if ();

  traffic_light_phase_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  tlpc_req_t requests_pending[$];
  tlpc_rsp_t lamps_due[$];

  // Model copy of the timing registers
  logic [3:0] m_yellow;
  logic [3:0] m_flash;
  logic [6:0] m_per_low;
  logic [6:0] m_per_high;
  logic [6:0] m_init_per;
  logic [7:0] m_ticks_sec;
  logic [7:0] m_ticks_fl;

  // Model state of the controller
  logic [2:0] m_phase;
  logic [6:0] m_secs;
  logic [6:0] m_reload;
  logic       m_run;
  logic [2:0] m_presses;
  logic [2:0] m_saved;
  logic [7:0] m_sec_pre;
  logic [7:0] m_flash_pre;
  logic       m_flash_off;

  logic      gaps_on;
  int        send_gap;
  int        sink_gap;
  int        quiet_cycles;
  int        mismatches;
  int        words_seen;
  tlpc_rsp_t lamp_next;
  tlpc_rsp_t lamp_want;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic reset_controller();
    m_yellow    = YellowRst;
    m_flash     = FlashRst;
    m_per_low   = PerLowRst;
    m_per_high  = PerHighRst;
    m_init_per  = InitPerRst;
    m_ticks_sec = TicksSecRst;
    m_ticks_fl  = TicksFlRst;
    m_phase     = PhNsGreen;
    m_secs      = InitPerRst;
    m_reload    = InitPerRst;
    m_run       = 1'b1;
    m_presses   = '0;
    m_saved     = PhNsGreen;
    m_sec_pre   = '0;
    m_flash_pre = '0;
    m_flash_off = 1'b1;
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      RegYellow:   m_yellow = val[3:0];
      RegFlash:    m_flash = val[3:0];
      RegPerLow:   m_per_low = val[6:0];
      RegPerHigh:  m_per_high = val[6:0];
      RegInitPer: begin
        m_init_per = val[6:0];
        m_secs     = val[6:0];
        m_reload   = val[6:0];
      end
      RegTicksSec: m_ticks_sec = val;
      RegTicksFl:  m_ticks_fl = val;
      default: ;
    endcase
  endtask

  // Apply one request word to the model and build the lamp word it yields
  task automatic step_lights(input tlpc_req_t w, output tlpc_rsp_t r);
    logic autop;
    logic green;
    int   sum;
    int   s;
    int   other;
    int   nc;
    int   ec;
    autop = (m_phase < PhAllYel);
    if (w.req_type == ReqTick) begin
      m_flash_pre = m_flash_pre + 8'd1;
      if (m_flash_pre >= m_ticks_fl) begin
        m_flash_pre = '0;
        m_flash_off = ~m_flash_off;
      end
      if (m_run && autop) begin
        m_sec_pre = m_sec_pre + 8'd1;
        if (m_sec_pre >= m_ticks_sec) begin
          m_sec_pre = '0;
          // reload and advance at the bottom, and advance on landing at the yellow point
          if (m_secs <= 7'd1) begin
            m_secs  = m_reload;
            m_phase = {1'b0, m_phase[1:0] + 2'd1};
          end else begin
            m_secs = m_secs - 7'd1;
          end
          if (m_secs == {3'd0, m_yellow}) m_phase = {1'b0, m_phase[1:0] + 2'd1};
        end
      end
    end else begin
      case (w.key_code)
        KeyStep: begin
          m_presses = m_presses + 3'd1;
          if (m_presses == 3'd1) m_saved = m_phase;
          m_run = 1'b0;
          if (m_presses >= 3'd4) begin
            m_phase   = (m_saved < PhAllYel) ? m_saved : PhNsGreen;
            m_run     = 1'b1;
            m_presses = '0;
          end else begin
            m_phase = PhEwYellow + m_presses;
          end
        end
        KeyInc: begin
          if (!m_run && autop && m_secs < m_per_high) begin
            sum      = m_secs + m_yellow;
            m_secs   = (sum > MaxCount) ? MaxCount : 7'(sum);
            m_reload = m_secs;
          end
        end
        KeyDec: begin
          if (!m_run && autop && m_secs > m_per_low) begin
            m_secs   = (m_secs > m_yellow + 1) ? 7'(m_secs - m_yellow) : 7'd1;
            m_reload = m_secs;
          end
        end
        KeyRun: begin
          if (autop) m_run = ~m_run;
        end
        default: ;
      endcase
    end

    s     = m_secs;
    other = (s > m_yellow) ? s - m_yellow : s;
    green = (s > m_yellow + m_flash) ? 1'b1 : ~m_flash_off;
    nc    = 0;
    ec    = 0;
    r     = '0;
    case (m_phase)
      PhNsGreen: begin
        r.ew_red   = 1'b1;
        r.ns_green = green;
        nc = s;
        ec = other;
      end
      PhNsYellow: begin
        r.ew_red    = 1'b1;
        r.ns_yellow = 1'b1;
        nc = s;
        ec = other;
      end
      PhEwGreen: begin
        r.ns_red   = 1'b1;
        r.ew_green = green;
        ec = s;
        nc = other;
      end
      PhEwYellow: begin
        r.ns_red    = 1'b1;
        r.ew_yellow = 1'b1;
        ec = s;
        nc = other;
      end
      PhAllYel: begin
        r.ns_yellow = 1'b1;
        r.ew_yellow = 1'b1;
      end
      PhEwGo: begin
        r.ew_green = 1'b1;
        r.ns_red   = 1'b1;
      end
      default: begin
        r.ns_green = 1'b1;
        r.ew_red   = 1'b1;
      end
    endcase
    r.ns_count = (nc > MaxCount) ? MaxCount : 7'(nc);
    r.ew_count = (ec > MaxCount) ? MaxCount : 7'(ec);
    r.phase    = m_phase;
    r.running  = m_run;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < PrintLimit)
      $display("word %0d: %s got %0d, want %0d", words_seen, field, got, want);
    mismatches++;
  endtask

  task automatic queue_word(input logic kind, input logic [2:0] code);
    tlpc_req_t w;
    w.req_type = kind;
    w.key_code = code;
    requests_pending.push_back(w);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(ReqTick, 3'($urandom_range(0, 7)));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
  endtask

  task automatic set_timing(input int yel, input int fl, input int low, input int high,
                            input int init, input int tps, input int tpf);
    write_reg(RegYellow, 8'(yel));
    write_reg(RegFlash, 8'(fl));
    write_reg(RegPerLow, 8'(low));
    write_reg(RegPerHigh, 8'(high));
    write_reg(RegInitPer, 8'(init));
    write_reg(RegTicksSec, 8'(tps));
    write_reg(RegTicksFl, 8'(tpf));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued word is sent and answered
  task automatic wait_idle();
    @(negedge clk_i);
    while (requests_pending.size() != 0 || req_if.valid || lamps_due.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic queue_random(input int n);
    int r;
    int steps;
    while (requests_pending.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_ticks($urandom_range(1, 16));
      end else if (r < 60) begin
        // pause, adjust the period, resume
        queue_word(ReqKey, KeyRun);
        repeat ($urandom_range(1, 6)) queue_word(ReqKey, $urandom_range(0, 1) ? KeyInc : KeyDec);
        if ($urandom_range(0, 3) == 0) queue_ticks($urandom_range(1, 4));
        queue_word(ReqKey, KeyRun);
      end else if (r < 72) begin
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 4;
        repeat (steps) begin
          queue_word(ReqKey, KeyStep);
          if ($urandom_range(0, 2) == 0) queue_ticks($urandom_range(1, 5));
          if ($urandom_range(0, 4) == 0) queue_word(ReqKey, 3'($urandom_range(KeyRun, KeyInc)));
        end
      end else if (r < 92) begin
        queue_word(ReqKey, 3'($urandom_range(KeyRun, KeyStep)));
      end else begin
        queue_word(ReqKey, $urandom_range(0, 1) ? KeyZero : 3'($urandom_range(KeyFive, KeySeven)));
      end
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    gaps_on      = 1'b1;
    send_gap     = 0;
    sink_gap     = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    words_seen   = 0;
    reset_controller();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    // Directed words at the reset timing
    queue_word(ReqTick, 3'b111);
    queue_word(ReqTick, 3'b000);
    queue_word(ReqTick, 3'b101);
    queue_word(ReqKey, KeyRun);
    queue_word(ReqKey, KeyInc);
    queue_word(ReqKey, KeyInc);
    queue_word(ReqKey, KeyDec);
    queue_word(ReqKey, KeyRun);
    queue_word(ReqKey, KeyInc);
    queue_word(ReqKey, KeyStep);
    queue_word(ReqKey, KeyRun);
    queue_word(ReqKey, KeyInc);
    queue_word(ReqKey, KeyDec);
    queue_word(ReqKey, KeyStep);
    queue_word(ReqKey, KeyStep);
    queue_word(ReqKey, KeyStep);
    queue_word(ReqKey, KeyZero);
    queue_word(ReqKey, KeyFive);
    queue_word(ReqKey, KeySix);
    queue_word(ReqKey, KeySeven);
    queue_word(ReqTick, 3'b010);
    queue_word(ReqTick, 3'b001);
    wait_idle();

    for (int b = 0; b < NumBursts; b++) begin
      case (b)
        0: ;
        1: set_timing(1, 0, 2, 99, 2, 1, 1);
        2: set_timing(9, 9, 99, 2, 99, 2, 3);
        3: set_timing(9, 9, 2, 99, 95, 1, 255);
        4: begin
          write_reg(RegUnmapped, 8'hFF);
          set_timing(3, 2, 10, 50, 120, 0, 0);
        end
        5: set_timing(4, 1, 30, 40, 35, 255, 2);
        default: set_timing($urandom_range(1, 9), $urandom_range(0, 9), $urandom_range(2, 99),
                             $urandom_range(2, 99), $urandom_range(2, 99),
                             $urandom_range(1, 6), $urandom_range(1, 12));
      endcase
      @(negedge clk_i);
      gaps_on = (b == NumBursts - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      queue_random(BurstItems);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        step_lights(req_if.data, lamp_next);
        lamps_due.push_back(lamp_next);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          if (gaps_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 14) - 1;
            req_if.valid <= 1'b0;
          end else begin
            req_if.valid <= 1'b1;
            req_if.data  <= requests_pending.pop_front();
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and sink
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (lamps_due.size() == 0) begin
          report_mismatch("word with none due", 1, 0);
        end else begin
          lamp_want = lamps_due.pop_front();
          if (rsp_if.data.ns_red !== lamp_want.ns_red)
            report_mismatch("ns_red", rsp_if.data.ns_red, lamp_want.ns_red);
          if (rsp_if.data.ns_yellow !== lamp_want.ns_yellow)
            report_mismatch("ns_yellow", rsp_if.data.ns_yellow, lamp_want.ns_yellow);
          if (rsp_if.data.ns_green !== lamp_want.ns_green)
            report_mismatch("ns_green", rsp_if.data.ns_green, lamp_want.ns_green);
          if (rsp_if.data.ew_red !== lamp_want.ew_red)
            report_mismatch("ew_red", rsp_if.data.ew_red, lamp_want.ew_red);
          if (rsp_if.data.ew_yellow !== lamp_want.ew_yellow)
            report_mismatch("ew_yellow", rsp_if.data.ew_yellow, lamp_want.ew_yellow);
          if (rsp_if.data.ew_green !== lamp_want.ew_green)
            report_mismatch("ew_green", rsp_if.data.ew_green, lamp_want.ew_green);
          if (rsp_if.data.ns_count !== lamp_want.ns_count)
            report_mismatch("ns_count", rsp_if.data.ns_count, lamp_want.ns_count);
          if (rsp_if.data.ew_count !== lamp_want.ew_count)
            report_mismatch("ew_count", rsp_if.data.ew_count, lamp_want.ew_count);
          if (rsp_if.data.phase !== lamp_want.phase)
            report_mismatch("phase", rsp_if.data.phase, lamp_want.phase);
          if (rsp_if.data.running !== lamp_want.running)
            report_mismatch("running", rsp_if.data.running, lamp_want.running);
        end
        words_seen++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 14) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
